FILE: sv/mhhm_pkg.sv
// Shared types and constants for the MMIO handler hash map.
// Holds the lowbias32 hash constants and the controller/datapath command and status structs.
// Depends on nothing; every other file refers to it by scoped names.
package mhhm_pkg;

  localparam logic [31:0] HashMul0 = 32'h7feb352d;
  localparam logic [31:0] HashMul1 = 32'h846ca68b;

  localparam logic ActGet = 1'b0;
  localparam logic ActPut = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // Capture the input beat.
    logic hash_mul0;   // First hash multiply.
    logic hash_mul1;   // Second hash multiply.
    logic head_rd;     // Read the bucket head.
    logic node_rd;     // Read the node at the chain pointer.
    logic step;        // Follow the next pointer.
    logic slot_wr;     // Write one handler slot of the found node.
    logic take;        // Capture the handler slot of the found node.
    logic alloc;       // Allocate a new node and link it.
    logic set_full;    // Report the pool as full.
  } mhhm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_put;
    logic class_ok;
    logic hid_zero;
    logic ptr_valid;   // Pointer below the fill count and step limit.
    logic key_match;
    logic pool_full;
  } mhhm_sts_t;

endpackage

FILE: sv/mhhm_ctrl.sv
// Controller state machine for the MMIO handler hash map.
// Sequences hash, head read, chain walk and update; uses mhhm_pkg structs.
module mhhm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mhhm_pkg::mhhm_sts_t sts_i,
  output mhhm_pkg::mhhm_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StMul0, StMul1, StHead, StHeadWait, StNode, StCheck, StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StMul0;
        end
      end
      StMul0: begin
        cmd_o.hash_mul0 = 1'b1;
        state_d         = StMul1;
      end
      StMul1: begin
        cmd_o.hash_mul1 = 1'b1;
        state_d         = StHead;
      end
      StHead: begin
        cmd_o.head_rd = 1'b1;
        state_d       = StHeadWait;
      end
      StHeadWait: begin
        state_d = StNode;
      end
      StNode: begin
        if (!sts_i.class_ok) begin
          state_d = StDone;
        end else if (sts_i.ptr_valid) begin
          cmd_o.node_rd = 1'b1;
          state_d       = StCheck;
        end else if (sts_i.is_put && !sts_i.hid_zero) begin
          if (sts_i.pool_full) begin
            cmd_o.set_full = 1'b1;
          end else begin
            cmd_o.alloc = 1'b1;
          end
          state_d = StDone;
        end else begin
          state_d = StDone;
        end
      end
      StCheck: begin
        if (sts_i.key_match) begin
          cmd_o.slot_wr = sts_i.is_put;
          cmd_o.take    = !sts_i.is_put;
          state_d       = StDone;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = StNode;
        end
      end
      StDone: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State and registered handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/mhhm_dp.sv
// Datapath for the MMIO handler hash map: hash unit, bucket heads, node pool memories.
// Driven by mhhm_ctrl commands; uses mhhm_pkg.
module mhhm_dp #(
  parameter int Buckets     = 256,
  parameter int PoolNodes   = 256,
  parameter int SizeClasses = 4,
  parameter int HandlerBits = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   action_i,
  input  logic [31:0]            bus_address_i,
  input  logic                   is_read_i,
  input  logic [1:0]             size_log2_i,
  input  logic [7:0]             handler_id_i,
  input  mhhm_pkg::mhhm_cmd_t    cmd_i,
  output mhhm_pkg::mhhm_sts_t    sts_o,
  output logic [7:0]             found_handler_o,
  output logic                   status_o
);

  localparam int BW = $clog2(Buckets);
  localparam int PW = $clog2(PoolNodes);
  localparam int CW = $clog2(PoolNodes + 1);
  localparam int SlotN = SizeClasses * 2;
  localparam int SW = (SlotN > 1) ? $clog2(SlotN) : 1;
  localparam int HW = SlotN * HandlerBits;

  // Bucket heads: a valid bit per bucket plus a memory of pointers.
  logic [Buckets-1:0]     head_vld_q;
  logic [PW-1:0]          head_mem [Buckets];
  logic [PW-1:0]          head_rd_q;
  logic                   head_hit_q;
  logic [31:0]            node_key [PoolNodes];
  logic [PW:0]            node_next [PoolNodes];   // Top bit set means end of chain.
  logic [HW-1:0]          node_hnd [PoolNodes];
  logic [31:0]            key_rd_q;
  logic [PW:0]            next_rd_q;
  logic [HW-1:0]          hnd_rd_q;

  logic                   act_q, dir_q;
  logic [1:0]             cls_q;
  logic [HandlerBits-1:0] hid_q;
  logic [31:0]            key_q, hash_q;
  logic [CW-1:0]          used_q, steps_q;
  logic [PW:0]            ptr_q;          // Top bit set means no node.
  logic [7:0]             found_q;
  logic                   status_q;
  logic                   from_head_q;

  logic [31:0] x0, x1, x2;
  logic [BW-1:0] bucket;
  logic [SW-1:0] slot;
  logic [PW:0]   head_ptr;
  logic [PW:0]   cur_ptr;
  logic [HW-1:0] hnd_new;

  assign x0     = key_q ^ (key_q >> 16);
  assign x1     = hash_q ^ (hash_q >> 15);
  assign x2     = hash_q ^ (hash_q >> 16);
  assign bucket = x2[BW-1:0];
  assign slot   = SW'({cls_q, dir_q});
  assign head_ptr = head_hit_q ? {1'b0, head_rd_q} : {1'b1, PW'(0)};
  assign cur_ptr  = from_head_q ? head_ptr : ptr_q;

  // Status to the controller.
  always_comb begin
    sts_o.is_put    = (act_q == mhhm_pkg::ActPut);
    sts_o.class_ok  = (32'(cls_q) < 32'(SizeClasses));
    sts_o.hid_zero  = (hid_q == '0);
    sts_o.ptr_valid = !cur_ptr[PW] && (CW'(cur_ptr[PW-1:0]) < used_q) && (steps_q < used_q);
    sts_o.key_match = (key_rd_q == key_q);
    sts_o.pool_full = (used_q >= CW'(PoolNodes));
  end

  // Slot update of the handler word.
  always_comb begin
    hnd_new = cmd_i.alloc ? '0 : hnd_rd_q;
    hnd_new[slot*HandlerBits +: HandlerBits] = hid_q;
  end

  // Input capture, hash, walk control and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= '0;
      used_q      <= '0;
      status_q    <= 1'b0;
      found_q     <= '0;
      from_head_q <= 1'b0;
      steps_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        act_q    <= action_i;
        key_q    <= bus_address_i;
        dir_q    <= is_read_i;
        cls_q    <= size_log2_i;
        hid_q    <= HandlerBits'(handler_id_i);
        found_q  <= '0;
        status_q <= 1'b0;
        steps_q  <= '0;
      end
      if (cmd_i.hash_mul0) hash_q <= x0 * mhhm_pkg::HashMul0;
      if (cmd_i.hash_mul1) hash_q <= x1 * mhhm_pkg::HashMul1;
      if (cmd_i.head_rd) begin
        head_hit_q  <= head_vld_q[bucket];
        from_head_q <= 1'b1;
      end
      if (cmd_i.node_rd) begin
        ptr_q       <= cur_ptr;
        from_head_q <= 1'b0;
      end
      if (cmd_i.step) begin
        ptr_q   <= next_rd_q;
        steps_q <= steps_q + CW'(1);
      end
      if (cmd_i.set_full) status_q <= 1'b1;
      if (cmd_i.alloc) begin
        head_vld_q[bucket] <= 1'b1;
        used_q             <= used_q + CW'(1);
      end
      if (cmd_i.take) begin
        found_q <= 8'(hnd_rd_q[slot*HandlerBits +: HandlerBits]);
      end
    end
  end

  // Memories: bucket heads and node pool.
  always_ff @(posedge clk_i) begin
    if (cmd_i.head_rd) head_rd_q <= head_mem[bucket];
    if (cmd_i.alloc) begin
      head_mem[bucket]       <= used_q[PW-1:0];
      node_key[used_q[PW-1:0]]  <= key_q;
      node_next[used_q[PW-1:0]] <= head_ptr;
      node_hnd[used_q[PW-1:0]]  <= hnd_new;
    end
    if (cmd_i.slot_wr) node_hnd[ptr_q[PW-1:0]] <= hnd_new;
    if (cmd_i.node_rd) begin
      key_rd_q  <= node_key[cur_ptr[PW-1:0]];
      next_rd_q <= node_next[cur_ptr[PW-1:0]];
      hnd_rd_q  <= node_hnd[cur_ptr[PW-1:0]];
    end
  end

  assign found_handler_o = found_q;
  assign status_o        = status_q;

endmodule

FILE: sv/mmio_handler_hash_map.sv
// MMIO handler hash map top level: controller plus datapath.
// Each request goes through hash, bucket head read, chain walk and update before its result is registered;
// each chain node visited adds a node read and a key check.
// One item at a time: a new request is taken only once the previous result has been accepted.
// Reset: asynchronous, active low; clears bucket valid bits, the node count and handshakes.
// Node memories are not cleared; a node is only read after it was allocated.
module mmio_handler_hash_map #(
  parameter int Buckets     = 256,
  parameter int PoolNodes   = 256,
  parameter int SizeClasses = 4,
  parameter int HandlerBits = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [3:0]  s_axis_tuser,   // action, is_read, size_log2[1:0]
  input  logic [39:0] s_axis_tdata,   // bus_address[31:0], handler_id[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // found_handler[7:0]
  output logic        m_axis_tuser    // status
);

  mhhm_pkg::mhhm_cmd_t cmd;
  mhhm_pkg::mhhm_sts_t sts;

  // Sequencing.
  mhhm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage and hashing.
  mhhm_dp #(
    .Buckets     (Buckets),
    .PoolNodes   (PoolNodes),
    .SizeClasses (SizeClasses),
    .HandlerBits (HandlerBits)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (s_axis_tuser[0]),
    .bus_address_i   (s_axis_tdata[31:0]),
    .is_read_i       (s_axis_tuser[1]),
    .size_log2_i     (s_axis_tuser[3:2]),
    .handler_id_i    (s_axis_tdata[39:32]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .found_handler_o (m_axis_tdata),
    .status_o        (m_axis_tuser)
  );

endmodule

FILE: tb/sv/mhhm_checker.sv
// Checker for the MMIO handler hash map: watches both streams, predicts each result
// from its own copy of the chained table, and counts mismatches.
// Depends on mhhm_pkg for the action codes.
`timescale 1ns / 100ps
module mhhm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [3:0]  s_axis_tuser,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          full_seen_o
);

  localparam int NBuckets = 256;
  localparam int NNodes   = 256;
  localparam int NClasses = 4;

  typedef struct packed {
    logic [7:0] handler;
    logic       full;
  } lookup_result_t;

  // Model of the table.
  int unsigned    head_q [NBuckets];
  logic [31:0]    key_q  [NNodes];
  int unsigned    next_q [NNodes];
  logic [7:0]     hdl_q  [NNodes][NClasses][2];
  int unsigned    fill_q;
  lookup_result_t due_q [$];

  // Bucket index from the two-multiply xorshift finalizer.
  function automatic int unsigned bucket_of(logic [31:0] a);
    logic [31:0] x;
    x = a;
    x = x ^ (x >> 16);
    x = x * 32'h7feb352d;
    x = x ^ (x >> 15);
    x = x * 32'h846ca68b;
    x = x ^ (x >> 16);
    return x % NBuckets;
  endfunction

  // Apply one request beat to the model and return the expected reply.
  function automatic lookup_result_t apply_request(logic act, logic [31:0] addr,
                                                   logic rd, logic [1:0] cls,
                                                   logic [7:0] hid);
    lookup_result_t r;
    int unsigned b, p, steps, n;
    r = '0;
    b = bucket_of(addr);
    p = head_q[b];
    steps = 0;
    n = NNodes;
    while (p < fill_q && p < NNodes && steps < fill_q) begin
      if (key_q[p] == addr) begin
        n = p;
        break;
      end
      p = next_q[p];
      steps++;
    end
    if (act == mhhm_pkg::ActGet) begin
      if (n != NNodes) r.handler = hdl_q[n][cls][rd];
    end else if (n != NNodes) begin
      hdl_q[n][cls][rd] = hid;
    end else if (hid != 0) begin
      if (fill_q >= NNodes) begin
        r.full = 1'b1;
      end else begin
        n = fill_q;
        key_q[n] = addr;
        next_q[n] = head_q[b];
        for (int c = 0; c < NClasses; c++) begin
          hdl_q[n][c][0] = '0;
          hdl_q[n][c][1] = '0;
        end
        hdl_q[n][cls][rd] = hid;
        head_q[b] = n;
        fill_q = n + 1;
      end
    end
    return r;
  endfunction

  assign pending_o = due_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < NBuckets; i++) head_q[i] = NNodes;
      fill_q = 0;
      due_q.delete();
      errors_o <= 0;
      results_o <= 0;
      full_seen_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        due_q.push_back(apply_request(s_axis_tuser[0], s_axis_tdata[31:0],
                                      s_axis_tuser[1], s_axis_tuser[3:2],
                                      s_axis_tdata[39:32]));
      // Compare each reply beat with the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        results_o <= results_o + 1;
        if (m_axis_tuser) full_seen_o <= full_seen_o + 1;
        if (due_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected reply beat: %h/%b", m_axis_tdata, m_axis_tuser);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = due_q.pop_front();
          if (exp_r.handler !== m_axis_tdata || exp_r.full !== m_axis_tuser) begin
            if (errors_o < 10)
              $display("reply mismatch: handler exp %h got %h, status exp %b got %b",
                       exp_r.handler, m_axis_tdata, exp_r.full, m_axis_tuser);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb.sv
// Testbench top for the MMIO handler hash map: drives request beats, stalls the
// reply side, and prints the verdict. Depends on mhhm_pkg and mhhm_checker.
`timescale 1ns / 100ps
module tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [3:0]  s_axis_tuser = '0;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  int          errors, pending, results, full_seen;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  logic [31:0] addr_pool [64];
  int          sent = 0;

  always #5 clk_i = ~clk_i;

  mmio_handler_hash_map uut (.*);

  mhhm_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending), .results_o(results),
    .full_seen_o(full_seen)
  );

  // Offer one request beat and wait until it is taken.
  task automatic send_request(logic act, logic [31:0] addr, logic rd,
                              logic [1:0] cls, logic [7:0] hid);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {cls, rd, act};
    s_axis_tdata  <= {hid, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Reply side: random stall bursts, one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int k, waited;
    logic [31:0] a;
    for (int i = 0; i < 64; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0;
    addr_pool[1] = 32'hffff_ffff;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, clear, zero put to new address, every size class and both directions.
    send_request(mhhm_pkg::ActGet, 32'h0, 1'b0, 2'd0, 8'h00);
    send_request(mhhm_pkg::ActPut, 32'h0, 1'b1, 2'd3, 8'hff);
    send_request(mhhm_pkg::ActGet, 32'h0, 1'b1, 2'd3, 8'h00);
    send_request(mhhm_pkg::ActGet, 32'h0, 1'b0, 2'd3, 8'h00);
    send_request(mhhm_pkg::ActPut, 32'hffff_ffff, 1'b0, 2'd0, 8'h01);
    send_request(mhhm_pkg::ActPut, 32'hffff_ffff, 1'b1, 2'd2, 8'h80);
    send_request(mhhm_pkg::ActGet, 32'hffff_ffff, 1'b0, 2'd0, 8'hff);
    send_request(mhhm_pkg::ActGet, 32'hffff_ffff, 1'b1, 2'd2, 8'h00);
    send_request(mhhm_pkg::ActPut, 32'hffff_ffff, 1'b0, 2'd0, 8'h00);
    send_request(mhhm_pkg::ActGet, 32'hffff_ffff, 1'b0, 2'd0, 8'h00);
    send_request(mhhm_pkg::ActPut, 32'h1234_5678, 1'b0, 2'd1, 8'h00);
    send_request(mhhm_pkg::ActGet, 32'h1234_5678, 1'b0, 2'd1, 8'h00);
    send_request(mhhm_pkg::ActPut, 32'haaaa_5555, 1'b1, 2'd1, 8'h55);
    send_request(mhhm_pkg::ActGet, 32'haaaa_5555, 1'b1, 2'd1, 8'haa);

    // Long reply hold-off while requests keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++)
      send_request(mhhm_pkg::ActGet, addr_pool[i % 4], i[0], i[2:1], 8'h00);

    // Random mix over a small address set so chains and hits are common.
    for (int i = 0; i < 500; i++) begin
      k = $urandom_range(0, 63);
      a = ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[k];
      send_request(1'($urandom_range(0, 1)), a, 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 8'($urandom));
    end

    // Fill the node pool with fresh addresses, then hit it while full.
    while (sent < 780) begin
      send_request(mhhm_pkg::ActPut, $urandom, 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 8'($urandom_range(1, 255)));
    end
    calm = 1'b1;
    for (int i = 0; i < 40; i++) begin
      k = $urandom_range(0, 63);
      send_request(1'($urandom_range(0, 1)), (i[0]) ? $urandom : addr_pool[k],
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   8'($urandom_range(1, 255)));
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (600) @(posedge clk_i);
    $display("tb: %0d requests sent, %0d replies checked, %0d pool-full replies", sent,
             results, full_seen);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

FILE: mmio_handler_hash_map.f
sv/mhhm_pkg.sv
sv/mhhm_ctrl.sv
sv/mhhm_dp.sv
sv/mmio_handler_hash_map.sv
tb/sv/mhhm_checker.sv
tb/sv/tb.sv
